>>> hw/rtl/pnveh_pkg.sv
// Package for the polygon nearest vertex / edge hit unit.
// Holds shared constants, input kind codes, the sequencer states and the divider status.
// No dependencies.
`default_nettype none
package pnveh_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;
	localparam int INDEX_BITS       = 6;
	localparam int KIND_BITS        = 2;
	localparam int T_BITS           = 17;
	localparam int CNT_BITS_DIV     = 5;
	localparam int RADIUS_BITS      = 8;
	localparam int APB_AW           = 3;
	localparam int APB_DW           = 32;

	localparam logic [T_BITS-1:0]      T_ONE        = 17'h10000;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 8'd8;
	localparam logic [0:0]             REG_HIT_RADIUS = 1'b0;

	localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_V_RD,
		ST_V_DIFF,
		ST_V_SQ,
		ST_V_CMP,
		ST_HIT,
		ST_E_RDA,
		ST_E_RDB,
		ST_E_AB,
		ST_E_SQ,
		ST_E_DOT,
		ST_E_TST,
		ST_E_DIV,
		ST_E_CP,
		ST_E_CPS,
		ST_E_ERR,
		ST_E_ESQ,
		ST_E_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/pnveh_vstore.sv
// Vertex memory: one write port and one read port with registered read data.
// Each word holds a vertex as {y, x}. Uses no package items.
`default_nettype none
module pnveh_vstore #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int W     = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/pnveh_div.sv
// Restoring divider for the edge parameter, one quotient bit per cycle.
// Depends on pnveh_pkg for T_BITS, CNT_BITS_DIV and the status struct.
`default_nettype none
module pnveh_div
	import pnveh_pkg::*;
#(
	parameter int DW = 34
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DW+T_BITS-1:0] dividend,
	input  wire logic [DW-1:0]        divisor,
	output logic      [T_BITS-1:0]    quotient,
	output div_stat_t                 stat
);

	logic [DW-1:0]           rem_q;
	logic [T_BITS-1:0]       num_q;
	logic [DW-1:0]           div_q;
	logic [T_BITS-1:0]       quo_q;
	logic [CNT_BITS_DIV-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DW:0]             trial;
	logic                    ge;

	assign trial = {rem_q, num_q[T_BITS-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS_DIV'(T_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS_DIV'(1);
				if (cnt_q == CNT_BITS_DIV'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW+T_BITS-1:T_BITS];
			num_q <= dividend[T_BITS-1:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			num_q <= {num_q[T_BITS-2:0], 1'b0};
			quo_q <= {quo_q[T_BITS-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

>>> hw/rtl/polygon_nearest_vertex_edge_hit_unit.sv
// Top level of the polygon nearest vertex / edge hit unit: sequencer, shared
// multipliers and register port. Depends on pnveh_pkg, pnveh_vstore and pnveh_div.
//
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  vertex or query point, tuser = kind
// m_*       out        m_tvalid/m_tready  hit result, tuser = flags
// APB       in         psel/penable       hit_radius register at address 0
//
// Clear and append words are taken in the idle state. A query makes a vertex pass over
// the n stored vertices, then, unless a vertex is hit or fewer than two are stored, an edge
// pass with the serial divider for interior projections, one vertex memory read a cycle.
// Reset clears the vertex count and sets the register to RADIUS_RESET; the memory holds no reset value.
// While a query runs s_tready is low; a finished result waits in the output register.
`default_nettype none
module polygon_nearest_vertex_edge_hit_unit
	import pnveh_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	localparam int IN_TW  = ((2*COORD_BITS+7)/8)*8,
	localparam int OUT_TW = ((INDEX_BITS+2*COORD_BITS+7)/8)*8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_TW-1:0]  s_tdata,  // point_x, point_y
	input  wire logic [KIND_BITS-1:0] s_tuser, // kind
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [OUT_TW-1:0] m_tdata,  // hit_index, closest_x, closest_y
	output logic      [1:0]        m_tuser,  // on_vertex, polygon_empty
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int C    = COORD_BITS;
	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW   = AW + 1;
	localparam int D    = C + 1;
	localparam int MW   = (D > T_BITS + 1) ? D : T_BITS + 1;
	localparam int PW   = 2 * MW;
	localparam int DW   = 2 * D;
	localparam int DOTW = 2 * D + 1;
	localparam int NW   = DW + T_BITS;
	localparam logic signed [PW-1:0] HALF_T = PW'(32768);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

	state_t state_q, state_d;

	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          idx_q;
	logic signed [C-1:0]    px_q, py_q, ax_q, ay_q, cx_q, cy_q, best_cx_q, best_cy_q;
	logic signed [D-1:0]    dx_q, dy_q, abx_q, aby_q;
	logic signed [PW-1:0]   prod0_q, prod1_q;
	logic [DW-1:0]          best_d_q, len2_q;
	logic [AW-1:0]          best_v_q, best_e_q;
	logic                   found_q, fin_on_q, fin_empty_q;
	logic [T_BITS-1:0]      t_q;
	logic [RADIUS_BITS-1:0] radius_q;
	logic [2*RADIUS_BITS-1:0] rsq_q;
	logic                   m_tvalid_q;
	logic [OUT_TW-1:0]      m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic                   s_fire, out_free, is_last, hit, cfg_wr;
	logic [AW-1:0]          next_idx, raddr;
	logic                   mem_we;
	logic [2*C-1:0]         rdata;
	logic signed [C-1:0]    rd_x, rd_y;
	logic signed [PW:0]     sum_pp;
	logic [DW-1:0]          d_cur;
	logic signed [DOTW-1:0] dot;
	logic signed [MW-1:0]   op_a0, op_b0, op_a1, op_b1;
	logic signed [PW-1:0]   rnd0, rnd1;
	logic                   div_start;
	logic [NW-1:0]          dividend;
	logic [T_BITS-1:0]      quotient;
	div_stat_t              div_stat;
	logic [INDEX_BITS-1:0]  res_idx;
	logic signed [C-1:0]    res_cx, res_cy;

	pnveh_vstore #(
		.DEPTH(MAX_VERTICES),
		.AW   (AW),
		.W    (2*C)
	) u_vstore (
		.clk  (clk),
		.we   (mem_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(s_tdata[2*C-1:0]),
		.raddr(raddr),
		.rdata(rdata)
	);

	pnveh_div #(
		.DW(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (len2_q),
		.quotient(quotient),
		.stat    (div_stat)
	);

	assign rd_x     = rdata[C-1:0];
	assign rd_y     = rdata[2*C-1:C];
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign is_last  = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign next_idx = is_last ? '0 : idx_q + AW'(1);
	assign sum_pp   = $signed({prod0_q[PW-1], prod0_q}) + $signed({prod1_q[PW-1], prod1_q});
	assign d_cur    = sum_pp[DW-1:0];
	assign dot      = sum_pp[DOTW-1:0];
	assign hit      = {{RADIUS_BITS*3{1'b0}}, best_d_q} <= {{DW{1'b0}}, rsq_q, 8'b0};
	assign rnd0     = prod0_q + HALF_T;
	assign rnd1     = prod1_q + HALF_T;
	assign dividend = NW'({dot[DW-1:0], 16'b0}) + NW'(len2_q >> 1);
	assign cfg_wr   = psel && penable && pwrite && pready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire && s_tuser == KIND_QUERY) begin
					state_d = (cnt_q == '0) ? ST_DONE : ST_V_RD;
				end
			end
			ST_V_RD:   state_d = ST_V_DIFF;
			ST_V_DIFF: state_d = ST_V_SQ;
			ST_V_SQ:   state_d = ST_V_CMP;
			ST_V_CMP:  state_d = is_last ? ST_HIT : ST_V_RD;
			ST_HIT: begin
				if (hit || cnt_q < CW'(2)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_E_RDA;
				end
			end
			ST_E_RDA:  state_d = ST_E_RDB;
			ST_E_RDB:  state_d = ST_E_AB;
			ST_E_AB:   state_d = ST_E_SQ;
			ST_E_SQ:   state_d = ST_E_DOT;
			ST_E_DOT:  state_d = ST_E_TST;
			ST_E_TST: begin
				if (len2_q == '0) begin
					state_d = is_last ? ST_DONE : ST_E_RDA;
				end else if (dot <= 0 || dot >= $signed({1'b0, len2_q})) begin
					state_d = ST_E_CP;
				end else begin
					state_d = ST_E_DIV;
				end
			end
			ST_E_DIV: begin
				if (div_stat.done) begin
					state_d = ST_E_CP;
				end
			end
			ST_E_CP:   state_d = ST_E_CPS;
			ST_E_CPS:  state_d = ST_E_ERR;
			ST_E_ERR:  state_d = ST_E_ESQ;
			ST_E_ESQ:  state_d = ST_E_CMP;
			ST_E_CMP:  state_d = is_last ? ST_DONE : ST_E_RDA;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		raddr     = idx_q;
		div_start = 1'b0;
		op_a0     = '0;
		op_b0     = '0;
		op_a1     = '0;
		op_b1     = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				mem_we   = s_tvalid && s_tuser == KIND_APPEND && cnt_q < MAX_CNT;
			end
			ST_E_RDB: raddr = next_idx;
			ST_V_SQ, ST_E_ESQ: begin
				op_a0 = MW'(dx_q);
				op_b0 = MW'(dx_q);
				op_a1 = MW'(dy_q);
				op_b1 = MW'(dy_q);
			end
			ST_E_SQ: begin
				op_a0 = MW'(abx_q);
				op_b0 = MW'(abx_q);
				op_a1 = MW'(aby_q);
				op_b1 = MW'(aby_q);
			end
			ST_E_DOT: begin
				op_a0 = MW'(dx_q);
				op_b0 = MW'(abx_q);
				op_a1 = MW'(dy_q);
				op_b1 = MW'(aby_q);
			end
			ST_E_TST: begin
				div_start = len2_q != '0 && dot > 0 && dot < $signed({1'b0, len2_q});
			end
			ST_E_CP: begin
				op_a0 = $signed(MW'(t_q));
				op_b0 = MW'(abx_q);
				op_a1 = $signed(MW'(t_q));
				op_b1 = MW'(aby_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (s_fire && s_tuser == KIND_CLEAR) begin
				cnt_q <= '0;
			end else if (mem_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod0_q <= op_a0 * op_b0;
		prod1_q <= op_a1 * op_b1;
		case (state_q)
			ST_IDLE: begin
				px_q        <= s_tdata[C-1:0];
				py_q        <= s_tdata[2*C-1:C];
				idx_q       <= '0;
				found_q     <= 1'b0;
				fin_on_q    <= 1'b0;
				fin_empty_q <= cnt_q == '0;
			end
			ST_V_DIFF: begin
				dx_q <= $signed({rd_x[C-1], rd_x}) - $signed({px_q[C-1], px_q});
				dy_q <= $signed({rd_y[C-1], rd_y}) - $signed({py_q[C-1], py_q});
			end
			ST_V_CMP: begin
				if (idx_q == '0 || d_cur < best_d_q) begin
					best_d_q <= d_cur;
					best_v_q <= idx_q;
				end
				idx_q <= next_idx;
			end
			ST_HIT: fin_on_q <= hit;
			ST_E_RDB: begin
				ax_q <= rd_x;
				ay_q <= rd_y;
			end
			ST_E_AB: begin
				abx_q <= $signed({rd_x[C-1], rd_x}) - $signed({ax_q[C-1], ax_q});
				aby_q <= $signed({rd_y[C-1], rd_y}) - $signed({ay_q[C-1], ay_q});
				dx_q  <= $signed({px_q[C-1], px_q}) - $signed({ax_q[C-1], ax_q});
				dy_q  <= $signed({py_q[C-1], py_q}) - $signed({ay_q[C-1], ay_q});
			end
			ST_E_DOT: len2_q <= d_cur;
			ST_E_TST: begin
				if (dot <= 0) begin
					t_q <= '0;
				end else begin
					t_q <= T_ONE;
				end
				if (len2_q == '0) begin
					idx_q <= next_idx;
				end
			end
			ST_E_DIV: begin
				if (div_stat.done) begin
					t_q <= (quotient > T_ONE) ? T_ONE : quotient;
				end
			end
			ST_E_CPS: begin
				cx_q <= C'(PW'(ax_q) + (rnd0 >>> 16));
				cy_q <= C'(PW'(ay_q) + (rnd1 >>> 16));
			end
			ST_E_ERR: begin
				dx_q <= $signed({px_q[C-1], px_q}) - $signed({cx_q[C-1], cx_q});
				dy_q <= $signed({py_q[C-1], py_q}) - $signed({cy_q[C-1], cy_q});
			end
			ST_E_CMP: begin
				if (!found_q || d_cur < best_d_q) begin
					found_q   <= 1'b1;
					best_d_q  <= d_cur;
					best_e_q  <= idx_q;
					best_cx_q <= cx_q;
					best_cy_q <= cy_q;
				end
				idx_q <= next_idx;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_idx = '0;
		res_cx  = '0;
		res_cy  = '0;
		if (fin_on_q) begin
			res_idx = INDEX_BITS'(best_v_q);
		end else if (found_q) begin
			res_idx = INDEX_BITS'(best_e_q);
			res_cx  = best_cx_q;
			res_cy  = best_cy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= OUT_TW'({res_cy, res_cx, res_idx});
			m_tuser_q <= {fin_empty_q, fin_on_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			rsq_q    <= (2*RADIUS_BITS)'(RADIUS_RESET * RADIUS_RESET);
		end else if (cfg_wr && paddr[2] == REG_HIT_RADIUS) begin
			radius_q <= pwdata[RADIUS_BITS-1:0];
			rsq_q    <= pwdata[RADIUS_BITS-1:0] * pwdata[RADIUS_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HIT_RADIUS) ? APB_DW'(radius_q) : '0;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("vertex count above capacity");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE && state_q != ST_HIT) |->
		CW'(idx_q) < cnt_q)
		else $error("vertex index beyond stored count");

	a_div_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_E_DIV |-> div_stat.busy || div_stat.done)
		else $error("waiting on an idle divider");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q[0] |-> !m_tuser_q[1])
		else $error("vertex hit reported on empty polygon");

endmodule
`default_nettype wire

>>> test/tb_polygon_nearest_vertex_edge_hit_unit.sv
// Testbench for polygon_nearest_vertex_edge_hit_unit: directed table, then random polygons and queries
// checked against an in-bench predictor, with random idling on both stream sides.
// Depends on pnveh_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module tb_polygon_nearest_vertex_edge_hit_unit;
	import pnveh_pkg::*;

	localparam int LIMIT = 12000000;
	localparam int DRAIN = 2600;

	typedef struct packed {
		logic        on_vertex;
		logic [5:0]  hit_index;
		logic [15:0] closest_x;
		logic [15:0] closest_y;
		logic        poly_empty;
	} hit_t;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] px;
		logic [15:0] py;
		bit          typed;
		hit_t        want;
	} row_t;

	logic clk = 0;
	logic arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	longint vert_x[MAX_VERTICES_DEF];
	longint vert_y[MAX_VERTICES_DEF];
	int vert_cnt = 0;
	int radius = RADIUS_RESET;
	hit_t expected_hits[$];
	int errors = 0;
	int cycles = 0;
	bit no_idle = 0;
	int words_sent = 0;
	row_t rows[$];

	polygon_nearest_vertex_edge_hit_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic hit_t hit_predict(logic signed [15:0] qx, logic signed [15:0] qy);
		hit_t r;
		longint px, py, dx, dy, d, best_d, r16, ax, ay, abx, aby, len2, dot, t, cx, cy;
		int best_v, j;
		bit found;
		r = '0;
		px = qx;
		py = qy;
		best_d = 0;
		best_v = 0;
		found = 0;
		if (vert_cnt == 0) begin
			r.poly_empty = 1;
			return r;
		end
		for (int i = 0; i < vert_cnt; i++) begin
			dx = vert_x[i] - px;
			dy = vert_y[i] - py;
			d = dx * dx + dy * dy;
			if (i == 0 || d < best_d) begin
				best_d = d;
				best_v = i;
			end
		end
		r16 = radius * 16;
		if (best_d <= r16 * r16) begin
			r.on_vertex = 1;
			r.hit_index = best_v[5:0];
			return r;
		end
		if (vert_cnt < 2)
			return r;
		for (int i = 0; i < vert_cnt; i++) begin
			j = (i + 1 == vert_cnt) ? 0 : i + 1;
			ax = vert_x[i];
			ay = vert_y[i];
			abx = vert_x[j] - ax;
			aby = vert_y[j] - ay;
			len2 = abx * abx + aby * aby;
			if (len2 == 0)
				continue;
			dot = (px - ax) * abx + (py - ay) * aby;
			if (dot <= 0)
				t = 0;
			else if (dot >= len2)
				t = 65536;
			else begin
				t = (dot * 65536 + len2 / 2) / len2;
				if (t > 65536)
					t = 65536;
			end
			cx = ax + ((t * abx + 32768) >>> 16);
			cy = ay + ((t * aby + 32768) >>> 16);
			dx = px - cx;
			dy = py - cy;
			d = dx * dx + dy * dy;
			if (!found || d < best_d) begin
				found = 1;
				best_d = d;
				r.hit_index = i[5:0];
				r.closest_x = cx[15:0];
				r.closest_y = cy[15:0];
			end
		end
		return r;
	endfunction

	task automatic send_word(logic [1:0] kind, logic [15:0] px, logic [15:0] py, bit typed,
			hit_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (kind == KIND_CLEAR)
			vert_cnt = 0;
		else if (kind == KIND_APPEND) begin
			if (vert_cnt < MAX_VERTICES_DEF) begin
				vert_x[vert_cnt] = longint'($signed(px));
				vert_y[vert_cnt] = longint'($signed(py));
				vert_cnt++;
			end
		end else if (kind == KIND_QUERY)
			expected_hits.push_back(typed ? want : hit_predict(px, py));
	endtask

	task automatic drain_results();
		s_tvalid <= 0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_radius(logic [7:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= '0;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		radius = value;
	endtask

	function automatic hit_t mk(bit onv, int idx, int cx, int cy, bit emp);
		hit_t h;
		h.on_vertex = onv;
		h.hit_index = idx[5:0];
		h.closest_x = cx[15:0];
		h.closest_y = cy[15:0];
		h.poly_empty = emp;
		return h;
	endfunction

	function automatic void add_row(logic [1:0] kind, int x, int y, bit typed, hit_t want);
		row_t r;
		r.kind = kind;
		r.px = x[15:0];
		r.py = y[15:0];
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endfunction

	// Receiver side: random stalls, and each word checked against the oldest expectation.
	initial begin
		hit_t got, want;
		int stall;
		m_tready <= 0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got.on_vertex = m_tuser[0];
			got.poly_empty = m_tuser[1];
			got.hit_index = m_tdata[5:0];
			got.closest_x = m_tdata[21:6];
			got.closest_y = m_tdata[37:22];
			if (expected_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, got %p", $time, got);
			end else begin
				want = expected_hits.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: expected %p, actual %p", $time, want, got);
				end
			end
		end
	end

	initial begin
		hit_t none;
		int nv, nq, mode, bx, by;
		none = '0;
		arst_n <= 0;
		s_tvalid <= 0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		add_row(KIND_QUERY, 0, 0, 1, mk(0, 0, 0, 0, 1));
		add_row(2'd3, 5, 5, 0, none);
		add_row(KIND_QUERY, 0, 0, 1, mk(0, 0, 0, 0, 1));
		add_row(KIND_APPEND, -32768, -32768, 0, none);
		add_row(KIND_QUERY, 32767, 32767, 1, mk(0, 0, 0, 0, 0));
		add_row(KIND_QUERY, -32768, -32768, 1, mk(1, 0, 0, 0, 0));
		add_row(KIND_APPEND, 32767, 32767, 0, none);
		add_row(KIND_APPEND, 32767, -32768, 0, none);
		add_row(KIND_QUERY, 0, 0, 0, none);
		add_row(KIND_QUERY, 32767, 32767, 1, mk(1, 1, 0, 0, 0));
		add_row(KIND_APPEND, 32767, -32768, 0, none);
		add_row(KIND_QUERY, 100, -20000, 0, none);
		add_row(KIND_CLEAR, 0, 0, 0, none);
		add_row(KIND_QUERY, 7, 7, 1, mk(0, 0, 0, 0, 1));
		add_row(KIND_APPEND, 0, 0, 0, none);
		add_row(KIND_APPEND, 0, 0, 0, none);
		add_row(KIND_QUERY, 1000, 1000, 1, mk(0, 0, 0, 0, 0));
		add_row(KIND_APPEND, 1600, 0, 0, none);
		add_row(KIND_APPEND, 1600, 1600, 0, none);
		add_row(KIND_QUERY, 800, -500, 0, none);
		add_row(KIND_QUERY, -500, -500, 0, none);
		add_row(KIND_QUERY, 1729, 800, 0, none);
		foreach (rows[k])
			send_word(rows[k].kind, rows[k].px, rows[k].py, rows[k].typed, rows[k].want);
		drain_results();

		while (words_sent < 1100) begin
			case ($urandom_range(0, 5))
				0: write_radius(8'd0);
				1: write_radius(8'd255);
				default: write_radius(8'($urandom_range(0, 255)));
			endcase
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) != 0)
				send_word(KIND_CLEAR, 16'($urandom), 16'($urandom), 0, none);
			mode = $urandom_range(0, 19);
			nv = (mode == 0) ? $urandom_range(60, 70) :
				(mode < 4) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			bx = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom))) :
				$urandom_range(0, 4000) - 2000;
			by = $urandom_range(0, 3) == 0 ? int'($signed(16'($urandom))) :
				$urandom_range(0, 4000) - 2000;
			for (int v = 0; v < nv; v++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(2'd3, 16'($urandom), 16'($urandom), 0, none);
				if ($urandom_range(0, 5) == 0)
					send_word(KIND_APPEND, 16'($urandom), 16'($urandom), 0, none);
				else if ($urandom_range(0, 9) == 0 && vert_cnt > 0)
					send_word(KIND_APPEND, vert_x[vert_cnt-1][15:0],
						vert_y[vert_cnt-1][15:0], 0, none);
				else
					send_word(KIND_APPEND, 16'(bx + $urandom_range(0, 6000) - 3000),
						16'(by + $urandom_range(0, 6000) - 3000), 0, none);
			end
			nq = (mode == 0) ? $urandom_range(2, 4) : $urandom_range(3, 10);
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(0, 4) == 0 || vert_cnt == 0)
					send_word(KIND_QUERY, 16'($urandom), 16'($urandom), 0, none);
				else begin
					nv = $urandom_range(0, vert_cnt - 1);
					send_word(KIND_QUERY,
						16'(vert_x[nv] + $urandom_range(0, 8000) - 4000),
						16'(vert_y[nv] + $urandom_range(0, 8000) - 4000), 0, none);
				end
			end
			drain_results();
		end

		no_idle = 0;
		s_tvalid <= 0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/pnveh_pkg.sv
hw/rtl/pnveh_vstore.sv
hw/rtl/pnveh_div.sv
hw/rtl/polygon_nearest_vertex_edge_hit_unit.sv
test/tb_polygon_nearest_vertex_edge_hit_unit.sv
